### hw/rtl/lcg_pkg.sv
// ----------------------------------------------------------------------------
// lcg_pkg
// shared types, register codes and width helpers for the lcg skip-ahead unit
// ----------------------------------------------------------------------------
package lcg_pkg;

  // generator width, 16 to 64
  localparam int SEED_BITS = 63;
  // width of register, input and result fields
  localparam int FIELD_W   = 63;
  // multiply-accumulate datapath width and multiplier half width
  localparam int WIDE_W    = 64;
  localparam int HALF_W    = 32;

  typedef logic [SEED_BITS-1:0] seed_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [1:0]           cfg_idx_t;

  localparam cfg_idx_t REG_MULTIPLIER     = 2'd0;
  localparam cfg_idx_t REG_INCREMENT      = 2'd1;
  localparam cfg_idx_t REG_BASE_SEED      = 2'd2;
  localparam cfg_idx_t REG_HISTORY_STRIDE = 2'd3;

  // request to the shared multiply-accumulate unit: a*b + c mod 2^SEED_BITS
  typedef struct packed {
    logic  start;
    seed_t a;
    seed_t b;
    seed_t c;
  } mac_req_t;

  typedef struct packed {
    logic  done;
    seed_t result;
  } mac_rsp_t;

  // field value reduced to the generator width
  function automatic seed_t to_seed(input field_t v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[SEED_BITS-1:0];
  endfunction

  // seed shown as a result field, low bits kept
  function automatic field_t to_field(input seed_t s);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(s);
    return w[FIELD_W-1:0];
  endfunction

endpackage

### hw/rtl/lcg_mac.sv
// ----------------------------------------------------------------------------
// lcg_mac
// multi-cycle modular multiply-accumulate on one 32x32 multiplier
// ----------------------------------------------------------------------------
module lcg_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  lcg_pkg::mac_req_t req,
  output lcg_pkg::mac_rsp_t rsp
);
  import lcg_pkg::*;

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_LL   = 2'd1;
  localparam logic [1:0] STEP_LH   = 2'd2;
  localparam logic [1:0] STEP_HL   = 2'd3;

  logic [1:0]        step_r;
  logic              done_r;
  logic [WIDE_W-1:0] a_r;
  logic [WIDE_W-1:0] b_r;
  logic [WIDE_W-1:0] acc_r;
  logic [HALF_W-1:0] mul_x;
  logic [HALF_W-1:0] mul_y;
  logic [WIDE_W-1:0] prod;
  logic [WIDE_W-1:0] addend;

  // high-by-high product falls outside 64 bits and is never formed
  always_comb begin
    mul_x  = (step_r == STEP_HL) ? a_r[WIDE_W-1:HALF_W] : a_r[HALF_W-1:0];
    mul_y  = (step_r == STEP_LH) ? b_r[WIDE_W-1:HALF_W] : b_r[HALF_W-1:0];
    prod   = WIDE_W'(mul_x) * WIDE_W'(mul_y);
    addend = (step_r == STEP_LL) ? prod : {prod[HALF_W-1:0], {HALF_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (step_r)
        STEP_IDLE: begin
          if (req.start) step_r <= STEP_LL;
        end
        STEP_LL: step_r <= STEP_LH;
        STEP_LH: step_r <= STEP_HL;
        STEP_HL: begin
          step_r <= STEP_IDLE;
          done_r <= 1'b1;
        end
        default: step_r <= STEP_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step_r == STEP_IDLE) begin
      if (req.start) begin
        a_r   <= WIDE_W'(req.a);
        b_r   <= WIDE_W'(req.b);
        acc_r <= WIDE_W'(req.c);
      end
    end else begin
      acc_r <= acc_r + addend;
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = acc_r[SEED_BITS-1:0];

endmodule

### hw/rtl/lcg_random_with_skip_ahead_unit.sv
// ----------------------------------------------------------------------------
// lcg_random_with_skip_ahead_unit
// linear congruential generator with skip-ahead to the start of a history
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | word
//  ---------+---------------------+------------------------------------------
//  in       | in_valid / in_stall | in_cmd, in_history_index
//  out      | out_valid/out_stall | out_random_fraction (draws only)
//  cfg      | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  every product goes through one shared multiply-accumulate unit; each
//  operation steps through issue, three 32x32 partial products and result
//  hand-back
//  a draw keeps in_stall high through one operation and the loading of the
//  output register, so a new draw is taken only once the last is finished
//  a history start keeps in_stall high through the skip-count product, the
//  square-and-multiply loop over the bits of history_index * stride (up to
//  four operations a bit) and the final seed operation
//  in_stall is high from acceptance until the word is finished; a finished
//  draw waits for a free output register, which the consumer can stall
//  reset (synchronous, active low) restores the register defaults and seed 1
//
module lcg_random_with_skip_ahead_unit (
  input  logic              clk,
  input  logic              rst_n,
  // input words
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_cmd,
  input  lcg_pkg::field_t   in_history_index,
  // result words
  output logic              out_valid,
  input  logic              out_stall,
  output lcg_pkg::field_t   out_random_fraction,
  // register writes
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  lcg_pkg::cfg_idx_t cfg_index,
  input  lcg_pkg::field_t   cfg_data
);
  import lcg_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DRAW  = 4'd1;   // seed = mult*seed + incr
  localparam logic [3:0] S_OUT   = 4'd2;   // hand the new seed to the output
  localparam logic [3:0] S_SKIP  = 4'd3;   // count = history * stride
  localparam logic [3:0] S_BIT   = 4'd4;   // look at the next count bit
  localparam logic [3:0] S_ACCM  = 4'd5;   // acc_mul *= pow_mul
  localparam logic [3:0] S_ACCA  = 4'd6;   // acc_add = acc_add*pow_mul + pow_add
  localparam logic [3:0] S_POWA  = 4'd7;   // pow_add = pow_mul*pow_add + pow_add
  localparam logic [3:0] S_POWM  = 4'd8;   // pow_mul squared, count shifted
  localparam logic [3:0] S_FINAL = 4'd9;   // seed = acc_mul*base + acc_add

  localparam seed_t SEED_ONE  = SEED_BITS'(1);
  localparam seed_t SEED_ZERO = '0;

  // configuration registers
  field_t     mult_r;
  field_t     incr_r;
  field_t     base_r;
  field_t     stride_r;

  // sequencer and generator state
  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       pending_r;
  seed_t      seed_r;

  // jump working set
  seed_t      count_r;
  seed_t      acc_mul_r;
  seed_t      acc_add_r;
  seed_t      pow_mul_r;
  seed_t      pow_add_r;

  // output register
  logic       out_valid_r;
  field_t     out_data_r;

  mac_req_t   mac_req;
  mac_rsp_t   mac_rsp;
  logic       op_state;
  logic       op_done;
  logic       in_accept;
  logic       out_load;

  lcg_mac u_mac (
    .clk (clk),
    .rst_n (rst_n),
    .req (mac_req),
    .rsp (mac_rsp)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // states that run one operation on the shared unit
  assign op_state = (state_r == S_DRAW) || (state_r == S_SKIP) ||
                    (state_r == S_ACCM) || (state_r == S_ACCA) ||
                    (state_r == S_POWA) || (state_r == S_POWM) ||
                    (state_r == S_FINAL);
  assign op_done  = pending_r && mac_rsp.done;

  // the output slot frees when empty or when its word is taken this cycle
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // operand selection for the shared unit
  always_comb begin
    mac_req.start = op_state && !pending_r;
    mac_req.a     = SEED_ZERO;
    mac_req.b     = SEED_ZERO;
    mac_req.c     = SEED_ZERO;
    unique case (state_r)
      S_DRAW: begin
        mac_req.a = to_seed(mult_r);
        mac_req.b = seed_r;
        mac_req.c = to_seed(incr_r);
      end
      S_SKIP: begin
        mac_req.a = count_r;
        mac_req.b = to_seed(stride_r);
      end
      S_ACCM: begin
        mac_req.a = acc_mul_r;
        mac_req.b = pow_mul_r;
      end
      S_ACCA: begin
        mac_req.a = acc_add_r;
        mac_req.b = pow_mul_r;
        mac_req.c = pow_add_r;
      end
      S_POWA: begin
        mac_req.a = pow_mul_r;
        mac_req.b = pow_add_r;
        mac_req.c = pow_add_r;
      end
      S_POWM: begin
        mac_req.a = pow_mul_r;
        mac_req.b = pow_mul_r;
      end
      S_FINAL: begin
        mac_req.a = acc_mul_r;
        mac_req.b = to_seed(base_r);
        mac_req.c = acc_add_r;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) state_nxt = in_cmd ? S_SKIP : S_DRAW;
      end
      S_DRAW:  if (op_done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      S_SKIP:  if (op_done) state_nxt = S_BIT;
      S_BIT: begin
        // loop ends once no set bits remain in the skip count
        if (count_r == SEED_ZERO) begin
          state_nxt = S_FINAL;
        end else if (count_r[0]) begin
          state_nxt = S_ACCM;
        end else begin
          state_nxt = S_POWA;
        end
      end
      S_ACCM:  if (op_done) state_nxt = S_ACCA;
      S_ACCA:  if (op_done) state_nxt = S_POWA;
      S_POWA:  if (op_done) state_nxt = S_POWM;
      S_POWM:  if (op_done) state_nxt = S_BIT;
      S_FINAL: if (op_done) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state, configuration and seed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
      seed_r      <= SEED_ONE;
      mult_r      <= FIELD_W'(64'd3512401965023503517);
      incr_r      <= '0;
      base_r      <= FIELD_W'(1);
      stride_r    <= FIELD_W'(152917);
    end else begin
      state_r <= state_nxt;

      if (mac_req.start) begin
        pending_r <= 1'b1;
      end else if (op_done) begin
        pending_r <= 1'b0;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (op_done && ((state_r == S_DRAW) || (state_r == S_FINAL))) begin
        seed_r <= mac_rsp.result;
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MULTIPLIER:     mult_r   <= cfg_data;
          REG_INCREMENT:      incr_r   <= cfg_data;
          REG_BASE_SEED:      base_r   <= cfg_data;
          REG_HISTORY_STRIDE: stride_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // jump working set and output word
  always_ff @(posedge clk) begin
    if (in_accept) begin
      count_r <= to_seed(in_history_index);
    end

    if (op_done) begin
      case (state_r)
        S_SKIP: begin
          // skip count, then the identity map and the one-step map
          count_r   <= mac_rsp.result;
          acc_mul_r <= SEED_ONE;
          acc_add_r <= SEED_ZERO;
          pow_mul_r <= to_seed(mult_r);
          pow_add_r <= to_seed(incr_r);
        end
        S_ACCM: acc_mul_r <= mac_rsp.result;
        S_ACCA: acc_add_r <= mac_rsp.result;
        S_POWA: pow_add_r <= mac_rsp.result;
        S_POWM: begin
          pow_mul_r <= mac_rsp.result;
          count_r   <= count_r >> 1;
        end
        default: begin
        end
      endcase
    end

    if (out_load) begin
      out_data_r <= to_field(seed_r);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_random_fraction = out_data_r;

endmodule

### tb/lcg_sequence_checker.sv
// ----------------------------------------------------------------------------
// lcg_sequence_checker
// watches the register, input and result channels of the lcg skip-ahead unit,
// keeps its own copy of the generator and compares every fraction it returns
// ----------------------------------------------------------------------------
module lcg_sequence_checker
  import lcg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  logic     in_cmd,
  input  field_t   in_history_index,
  input  logic     out_valid,
  input  logic     out_stall,
  input  field_t   out_random_fraction,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  field_t   cfg_data,
  output int       fail_count,
  output int       pending
);

  // command codes on in_cmd
  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_START = 1'b1;

  seed_t  mult_q, incr_q, base_q, stride_q;
  seed_t  seed_q;
  field_t expected_fractions[$];
  int     errors;
  int     draws_seen;

  initial begin
    errors     = 0;
    draws_seen = 0;
  end

  // affine map x -> m*x + c applied count times, by squaring the map
  function automatic seed_t jump_seed(input seed_t from, input seed_t count);
    seed_t acc_m, acc_c, pow_m, pow_c;
    int    b;
    acc_m = seed_t'(1);
    acc_c = '0;
    pow_m = mult_q;
    pow_c = incr_q;
    for (b = 0; b < SEED_BITS; b++) begin
      if (count[b]) begin
        acc_m = acc_m * pow_m;
        acc_c = acc_c * pow_m + pow_c;
      end
      pow_c = pow_m * pow_c + pow_c;
      pow_m = pow_m * pow_m;
    end
    return acc_m * from + acc_c;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      mult_q   = seed_t'(63'd3512401965023503517);
      incr_q   = '0;
      base_q   = seed_t'(1);
      stride_q = seed_t'(63'd152917);
      seed_q   = seed_t'(1);
      expected_fractions.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MULTIPLIER:     mult_q   = seed_t'(cfg_data);
          REG_INCREMENT:      incr_q   = seed_t'(cfg_data);
          REG_BASE_SEED:      base_q   = seed_t'(cfg_data);
          REG_HISTORY_STRIDE: stride_q = seed_t'(cfg_data);
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        draws_seen++;
        if (expected_fractions.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: fraction %h returned with no draw outstanding",
                     $time, out_random_fraction);
        end else begin
          if (out_random_fraction !== expected_fractions[0]) begin
            errors++;
            if (errors <= 10)
              $display("%0t: word %0d random_fraction expected %h, got %h",
                       $time, draws_seen, expected_fractions[0], out_random_fraction);
          end
          void'(expected_fractions.pop_front());
        end
      end

      if (in_valid && !in_stall) begin
        if (in_cmd == CMD_START) begin
          seed_q = jump_seed(base_q, seed_t'(in_history_index) * stride_q);
        end else if (in_cmd == CMD_DRAW) begin
          seed_q = mult_q * seed_q + incr_q;
          expected_fractions.push_back(field_t'(seed_q));
        end
      end
    end
    pending    <= expected_fractions.size();
    fail_count <= errors;
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus for the lcg skip-ahead unit: register settings from reset values to
// all-ones and all-zeros and random ones, draws and history starts, random
// gaps on both channels and one long hold-off of the result side
// ----------------------------------------------------------------------------
module tb;
  import lcg_pkg::*;

  localparam logic CMD_DRAW  = 1'b0;
  localparam logic CMD_START = 1'b1;

  // long enough for the longest history start, so this covers a word
  // still busy after the last fraction has come back
  localparam int DRAIN_CYCLES = 1500;

  localparam field_t ALL_ONES = '1;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  logic     in_cmd;
  field_t   in_history_index;
  logic     out_valid;
  logic     out_stall;
  field_t   out_random_fraction;
  logic     cfg_valid;
  logic     cfg_ready;
  cfg_idx_t cfg_index;
  field_t   cfg_data;

  int       fail_count;
  int       pending;

  // when set, neither side idles
  bit       calm;
  int       random_sent;

  lcg_random_with_skip_ahead_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_history_index    (in_history_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_random_fraction (out_random_fraction),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  lcg_sequence_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_history_index    (in_history_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_random_fraction (out_random_fraction),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .fail_count          (fail_count),
    .pending             (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard stop, several times the slowest run even if every word were a
  // full-length history start
  initial begin
    #200000000;
    $display("tb: errors");
    $finish;
  end

  // full-width random value, every bit free
  function automatic field_t rand_field();
    return field_t'({$urandom, $urandom});
  endfunction

  // history numbers: mostly small so skips stay short, some full width and
  // some on the edges (zero, all ones, a single bit)
  function automatic field_t pick_history();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60)
      return field_t'($urandom_range(0, 2000));
    else if (roll < 85)
      return rand_field();
    else if (roll < 90)
      return '0;
    else if (roll < 95)
      return ALL_ONES;
    else
      return field_t'(1) << $urandom_range(0, FIELD_W - 1);
  endfunction

  // offer one word and hold it until it is taken
  task automatic send_word(input logic cmd, input field_t hist);
    while (!calm && $urandom_range(0, 99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_cmd           <= cmd;
    in_history_index <= hist;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly draws, about one word in seven a history start; the payload of a
  // draw is random as the unit must ignore it
  task automatic send_random(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      calm = (random_sent >= 200 && random_sent < 350);
      if ($urandom_range(0, 99) < 15)
        send_word(CMD_START, pick_history());
      else
        send_word(CMD_DRAW, rand_field());
      random_sent++;
    end
    calm = 1'b0;
  endtask

  // let every outstanding fraction come back and any start finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input field_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_settings(input field_t mult, input field_t incr,
                               input field_t base, input field_t stride);
    write_reg(REG_MULTIPLIER, mult);
    write_reg(REG_INCREMENT, incr);
    write_reg(REG_BASE_SEED, base);
    write_reg(REG_HISTORY_STRIDE, stride);
    cfg_valid <= 1'b0;
  endtask

  // result side: random stall, one long hold-off once some fractions are in
  initial begin : consumer
    int  taken;
    int  hold_left;
    bit  held;
    taken     = 0;
    hold_left = 0;
    held      = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) taken++;
      // long hold-off so the unit backs up and stalls its input
      if (!held && taken == 60) begin
        held      = 1'b1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  // stimulus and verdict
  initial begin : producer
    int p;
    field_t stride;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_cmd           = CMD_DRAW;
    in_history_index = '0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_MULTIPLIER;
    cfg_data         = '0;
    calm             = 1'b0;
    random_sent      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: plain draws, zero skip gives the base seed back,
    // large history numbers wrap the skip count
    send_word(CMD_DRAW, '0);
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, '0);
    send_word(CMD_DRAW, '0);
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, field_t'(1));
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, ALL_ONES);
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, field_t'(1) << (FIELD_W - 1));
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, field_t'({FIELD_W{2'b10}} >> 1));
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, field_t'(12345));
    send_word(CMD_DRAW, '0);
    send_word(CMD_DRAW, ALL_ONES);
    send_random(400);
    settle();

    // every register at its top value
    load_settings(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
    send_word(CMD_START, '0);
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, ALL_ONES);
    send_word(CMD_DRAW, ALL_ONES);
    send_word(CMD_DRAW, '0);
    send_random(200);
    settle();

    // every register zero: the generator collapses onto zero
    load_settings('0, '0, '0, '0);
    send_word(CMD_DRAW, '0);
    send_word(CMD_START, field_t'(7));
    send_word(CMD_DRAW, '0);
    send_word(CMD_DRAW, '0);
    send_random(50);
    settle();

    // random settings, stride mostly small so starts stay short
    for (p = 0; p < 3; p++) begin
      stride = (p == 2) ? rand_field() : field_t'($urandom_range(1, 1 << 20));
      load_settings(rand_field() | field_t'(p != 1), (p == 0) ? '0 : rand_field(),
                    rand_field(), stride);
      send_random(300);
      settle();
    end

    if (fail_count == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule

### lcg_random_with_skip_ahead_unit.f
hw/rtl/lcg_pkg.sv
hw/rtl/lcg_mac.sv
hw/rtl/lcg_random_with_skip_ahead_unit.sv
tb/lcg_sequence_checker.sv
tb/tb.sv
